// File: rtl/b64_pkg.sv
// Shared constants, result codes and character classification for the Base64 decoder.
// No dependencies; every other file in rtl/ refers to it by scoped names.
`default_nettype none

package b64_pkg;

    localparam int CMD_W    = 1;
    localparam int CHAR_W   = 8;
    localparam int KIND_W   = 2;
    localparam int BYTE_W   = 8;
    localparam int SEXTET_W = 6;
    localparam int MAX_RES  = 3;

    typedef logic [KIND_W-1:0]   kind_t;
    typedef logic [CHAR_W-1:0]   char_t;
    typedef logic [SEXTET_W-1:0] sextet_t;

    localparam kind_t KIND_DATA = 2'd0;
    localparam kind_t KIND_OK   = 2'd1;
    localparam kind_t KIND_BAD  = 2'd2;

    localparam logic [CMD_W-1:0] CMD_CHAR = 1'b0;
    localparam logic [CMD_W-1:0] CMD_END  = 1'b1;

    localparam char_t PAD_CHAR = 8'h3D;

    typedef struct packed {
        logic    hit;
        sextet_t value;
    } sextet_lookup_t;

    // Map a character of the standard alphabet to its sextet.
    function automatic sextet_lookup_t sextet_of(input char_t c);
        sextet_lookup_t r;
        r.hit   = 1'b1;
        r.value = '0;
        if (c inside {[8'h41:8'h5A]})
            r.value = SEXTET_W'(c - 8'h41);
        else if (c inside {[8'h61:8'h7A]})
            r.value = SEXTET_W'(c - 8'h61 + 8'd26);
        else if (c inside {[8'h30:8'h39]})
            r.value = SEXTET_W'(c - 8'h30 + 8'd52);
        else if (c == 8'h2B)
            r.value = 6'd62;
        else if (c == 8'h2F)
            r.value = 6'd63;
        else
            r.hit = 1'b0;
        return r;
    endfunction

    function automatic logic is_blank(input char_t c);
        return (c inside {[8'h09:8'h0D], 8'h20});
    endfunction

endpackage

`default_nettype wire

// File: rtl/b64_text_if.sv
// Request channel carrying one text character or an end-of-text marker.
// Depends on b64_pkg for field widths.
`default_nettype none

interface b64_text_if;
    logic                        valid;
    logic                        ready;
    logic [b64_pkg::CMD_W-1:0]   command;
    logic [b64_pkg::CHAR_W-1:0]  text_char;

    modport source (output valid, command, text_char, input ready);
    modport sink   (input valid, command, text_char, output ready);
endinterface

`default_nettype wire

// File: rtl/b64_result_if.sv
// Request channel carrying one decoded byte or a final status.
// Depends on b64_pkg for field widths.
`default_nettype none

interface b64_result_if;
    logic                        valid;
    logic                        ready;
    logic [b64_pkg::KIND_W-1:0]  kind;
    logic [b64_pkg::BYTE_W-1:0]  data_byte;
    logic                        last;

    modport source (output valid, kind, data_byte, last, input ready);
    modport sink   (input valid, kind, data_byte, last, output ready);
endinterface

`default_nettype wire

// File: rtl/base64_stream_decoder.sv
// Lenient Base64 decoder, standard alphabet, one character per request.
// Depends on b64_pkg, b64_text_if and b64_result_if.
//
//  channel | direction | payload                      | handshake
//  text    | sink      | command, text_char           | valid/ready
//  result  | source    | kind, data_byte, last        | valid/ready
//
// A text request is decoded in the cycle it is taken; its 0..3 results land in
// a small result register and leave one per cycle while the result port is ready.
// A new request is taken when the result register is empty or its last entry
// is being taken, so each request waits for all results of the one before it.
// Reset clears the group state, the sticky error and the result count and index.
// A stalled result port holds its entry and blocks text until the last entry is taken.
`default_nettype none

module base64_stream_decoder (
    input  wire logic         clk,
    input  wire logic         rst_n,
    b64_text_if.sink          text,
    b64_result_if.source      result
);

    localparam int CNT_W = $clog2(b64_pkg::MAX_RES + 1);
    localparam int IDX_W = $clog2(b64_pkg::MAX_RES);

    // Group state
    b64_pkg::sextet_t  sextet_reg [3];
    b64_pkg::sextet_t  sextet_next [3];
    logic [1:0]        group_cnt_reg, group_cnt_next;
    logic [1:0]        pad_cnt_reg, pad_cnt_next;
    logic              padded_reg, padded_next;
    logic              err_reg, err_next;

    // Result register
    b64_pkg::kind_t    res_kind_reg [b64_pkg::MAX_RES];
    logic [7:0]        res_byte_reg [b64_pkg::MAX_RES];
    b64_pkg::kind_t    res_kind_next [b64_pkg::MAX_RES];
    logic [7:0]        res_byte_next [b64_pkg::MAX_RES];
    logic [CNT_W-1:0]  rem_reg;
    logic [IDX_W-1:0]  pos_reg;
    logic [CNT_W-1:0]  res_cnt;

    logic              text_fire;
    logic              result_fire;

    b64_pkg::sextet_lookup_t lookup;
    b64_pkg::sextet_t        sextet_val;
    logic [7:0]              byte0, byte1;

    assign result_fire = result.valid && result.ready;
    assign text.ready  = (rem_reg == '0) || ((rem_reg == CNT_W'(1)) && result.ready);
    assign text_fire   = text.valid && text.ready;

    assign result.valid     = (rem_reg != '0);
    assign result.kind      = res_kind_reg[pos_reg];
    assign result.data_byte = res_byte_reg[pos_reg];
    assign result.last      = (rem_reg == CNT_W'(1));

    assign lookup = b64_pkg::sextet_of(text.text_char);

    always_comb
    begin
        sextet_next    = sextet_reg;
        group_cnt_next = group_cnt_reg;
        pad_cnt_next   = pad_cnt_reg;
        padded_next    = padded_reg;
        err_next       = err_reg;
        res_cnt        = '0;
        sextet_val     = lookup.value;
        for (int i = 0; i < b64_pkg::MAX_RES; i++)
        begin
            res_kind_next[i] = b64_pkg::KIND_DATA;
            res_byte_next[i] = '0;
        end

        if (text.command == b64_pkg::CMD_END)
        begin
            if (err_reg || group_cnt_reg == 2'd1)
            begin
                res_kind_next[0] = b64_pkg::KIND_BAD;
                res_cnt          = CNT_W'(1);
            end
            else
            begin
                case (group_cnt_reg)
                    2'd2:
                    begin
                        res_byte_next[0] = byte0;
                        res_kind_next[1] = b64_pkg::KIND_OK;
                        res_cnt          = CNT_W'(2);
                    end
                    2'd3:
                    begin
                        res_byte_next[0] = byte0;
                        res_byte_next[1] = byte1;
                        res_kind_next[2] = b64_pkg::KIND_OK;
                        res_cnt          = CNT_W'(3);
                    end
                    default:
                    begin
                        res_kind_next[0] = b64_pkg::KIND_OK;
                        res_cnt          = CNT_W'(1);
                    end
                endcase
            end
            for (int i = 0; i < 3; i++)
                sextet_next[i] = '0;
            group_cnt_next = '0;
            pad_cnt_next   = '0;
            padded_next    = 1'b0;
            err_next       = 1'b0;
        end
        else if (!(err_reg || b64_pkg::is_blank(text.text_char)))
        begin
            if (padded_reg)
                err_next = 1'b1;
            else if (text.text_char == b64_pkg::PAD_CHAR && pad_cnt_reg >= 2'd2)
                err_next = 1'b1;
            else if (text.text_char != b64_pkg::PAD_CHAR && !lookup.hit)
                err_next = 1'b1;
            else
            begin
                if (text.text_char == b64_pkg::PAD_CHAR)
                begin
                    pad_cnt_next = pad_cnt_reg + 2'd1;
                    sextet_val   = '0;
                end
                if (group_cnt_reg != 2'd3)
                begin
                    sextet_next[group_cnt_reg] = sextet_val;
                    group_cnt_next             = group_cnt_reg + 2'd1;
                end
                else
                begin
                    // Group complete: pads drop bytes from the tail
                    res_byte_next[0] = byte0;
                    res_byte_next[1] = byte1;
                    res_byte_next[2] = {sextet_reg[2][1:0], sextet_val};
                    res_cnt          = CNT_W'(3) - CNT_W'(pad_cnt_next);
                    padded_next      = (pad_cnt_next != 2'd0);
                    group_cnt_next   = '0;
                    pad_cnt_next     = '0;
                end
            end
        end
    end

    assign byte0 = {sextet_reg[0], sextet_reg[1][5:4]};
    assign byte1 = {sextet_reg[1][3:0], sextet_reg[2][5:2]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 3; i++)
                sextet_reg[i] <= '0;
            group_cnt_reg <= '0;
            pad_cnt_reg   <= '0;
            padded_reg    <= 1'b0;
            err_reg       <= 1'b0;
            rem_reg       <= '0;
            pos_reg       <= '0;
        end
        else
        begin
            if (text_fire)
            begin
                sextet_reg    <= sextet_next;
                group_cnt_reg <= group_cnt_next;
                pad_cnt_reg   <= pad_cnt_next;
                padded_reg    <= padded_next;
                err_reg       <= err_next;
                rem_reg       <= res_cnt;
                pos_reg       <= '0;
            end
            else if (result_fire)
            begin
                rem_reg <= rem_reg - CNT_W'(1);
                pos_reg <= pos_reg + IDX_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (text_fire)
        begin
            res_kind_reg <= res_kind_next;
            res_byte_reg <= res_byte_next;
        end
    end

    // Head and remaining count never run past the result register
    a_res_bound: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> ({1'b0, pos_reg} + {1'b0, rem_reg}) <= 3'(b64_pkg::MAX_RES))
        else $error("result register index overrun");

    a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        text_fire && text.command == b64_pkg::CMD_END |=>
            group_cnt_reg == 2'd0 && pad_cnt_reg == 2'd0 && !padded_reg && !err_reg)
        else $error("end of text left group state behind");

    a_err_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        err_reg && !(text_fire && text.command == b64_pkg::CMD_END) |=> err_reg)
        else $error("sticky error dropped without end of text");

    a_pad_limit: assert property (@(posedge clk) disable iff (!rst_n)
        pad_cnt_reg != 2'd3 && !(padded_reg && group_cnt_reg != 2'd0))
        else $error("pad bookkeeping out of range");

    a_end_result: assert property (@(posedge clk) disable iff (!rst_n)
        text_fire && text.command == b64_pkg::CMD_END |=> result.valid)
        else $error("end of text gave no status");

endmodule

`default_nettype wire
